/* rtl/nbpfi_pkg.sv */
package nbpfi_pkg;

   localparam int NumParticlesDefault = 8;
   localparam int IdxW = 3;
   localparam logic [31:0] TimeStepReset = 32'd429497;
   localparam logic [30:0] MinDistReset = 31'd13107;
   localparam logic signed [47:0] ForceMax = 48'sh7FFF_FFFF_FFFF;

   localparam logic CsrTimeStep = 1'b0;
   localparam logic CsrMinDist = 1'b1;

   localparam logic ReqLoad = 1'b0;
   localparam logic ReqStep = 1'b1;

   typedef struct packed {
      logic req_type;
      logic [2:0] particle_index;
      logic signed [31:0] load_pos_x;
      logic signed [31:0] load_pos_y;
      logic signed [31:0] load_pos_z;
      logic signed [31:0] load_vel_x;
      logic signed [31:0] load_vel_y;
      logic signed [31:0] load_vel_z;
      logic [15:0] load_mass;
   } req_type_type;

   typedef struct packed {
      logic [2:0] out_index;
      logic signed [31:0] out_pos_x;
      logic signed [31:0] out_pos_y;
      logic signed [31:0] out_pos_z;
      logic out_last;
   } rsp_type_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_CLEAR, ST_PF_RD, ST_PF_DIV, ST_PF_ACC,
      ST_UP_RD, ST_UP_DIV, ST_UP_MUL, ST_UP_WR, ST_EMIT
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic clear;
      logic pf_read;
      logic div_start;
      logic pf_acc;
      logic up_read;
      logic up_mul;
      logic up_write;
      logic emit;
      logic [5:0] j;
      logic [5:0] k;
      logic [1:0] axis;
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic mul_done;
   } sts_type;

   function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
      if (v > 50'sd2147483647) return 32'sh7FFF_FFFF;
      if (v < -50'sd2147483648) return 32'sh8000_0000;
      return v[31:0];
   endfunction

endpackage

/* rtl/nbpfi_div.sv */
// restoring divider, one quotient bit per cycle, with early saturation
module nbpfi_div (
   input logic clock,
   input logic reset,
   input logic start,
   input logic [79:0] dividend,
   input logic [63:0] divisor,
   input logic [6:0] nbits,
   input logic [63:0] qmax,
   output logic done,
   output logic [63:0] quotient
);

   logic [79:0] num_ff, num_in;
   logic [64:0] rem_ff, rem_in;
   logic [63:0] q_ff, q_in;
   logic [63:0] den_ff, den_in;
   logic [63:0] max_ff, max_in;
   logic [6:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in;
   logic done_ff, done_in;
   logic [64:0] sh;
   logic [63:0] qn;

   always_comb begin
      num_in = num_ff;
      rem_in = rem_ff;
      q_in = q_ff;
      den_in = den_ff;
      max_in = max_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      sh = {rem_ff[63:0], num_ff[79]};
      qn = {q_ff[62:0], 1'b0};
      if (start) begin
         num_in = dividend << (7'd80 - nbits);
         rem_in = '0;
         q_in = '0;
         den_in = divisor;
         max_in = qmax;
         cnt_in = nbits;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in = {num_ff[78:0], 1'b0};
         if (sh >= {1'b0, den_ff}) begin
            rem_in = sh - {1'b0, den_ff};
            qn[0] = 1'b1;
         end else begin
            rem_in = sh;
         end
         q_in = qn;
         cnt_in = cnt_ff - 7'd1;
         if (qn > max_ff) begin
            q_in = max_ff;
            busy_in = 1'b0;
            done_in = 1'b1;
         end else if (cnt_ff == 7'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
      q_ff <= q_in;
      den_ff <= den_in;
      max_ff <= max_in;
      cnt_ff <= cnt_in;
   end

   assign done = done_ff;
   assign quotient = q_ff;

endmodule

/* rtl/nbpfi_datapath.sv */
module nbpfi_datapath #(
   parameter int NUM_PARTICLES = nbpfi_pkg::NumParticlesDefault,
   localparam int AW = $clog2(NUM_PARTICLES)
) (
   input logic clock,
   input logic reset,
   input nbpfi_pkg::cmd_type cmd,
   output nbpfi_pkg::sts_type sts,
   input nbpfi_pkg::req_type_type req_data,
   input logic [31:0] time_step,
   input logic [30:0] min_distance,
   output nbpfi_pkg::rsp_type_type rsp_data
);

   logic signed [31:0] pos_mem [NUM_PARTICLES*3];
   logic signed [31:0] vel_mem [NUM_PARTICLES*3];
   logic [15:0] mass_mem [NUM_PARTICLES];
   logic signed [47:0] force_ff [NUM_PARTICLES*3];

   logic signed [31:0] xj_ff, xk_ff, vel_ff;
   logic [15:0] mj_ff, mk_ff;
   logic signed [47:0] f_ff;
   logic signed [31:0] res_ff [3];

   logic div_start;
   logic [79:0] div_a;
   logic [63:0] div_b, div_max, div_q;
   logic [6:0] div_n;
   logic div_done;

   logic signed [32:0] dx;
   logic [32:0] mag, mag_c;
   logic [31:0] dmin;
   logic [47:0] fabs;
   logic [15:0] mj_eff;

   // update stage registers
   logic signed [47:0] acc_ff;
   logic signed [63:0] adt_ff, half_ff, vdt_ff;
   logic [2:0] mstep_ff;
   logic signed [81:0] prod_hi, prod_lo;
   logic signed [63:0] tmp_ff;
   logic signed [31:0] np;
   logic signed [49:0] pos_sum;

   function automatic logic signed [63:0] fshr(input logic signed [81:0] v, input int s);
      logic signed [81:0] t;
      t = v >>> s;
      return t[63:0];
   endfunction

   localparam int NI = NUM_PARTICLES * 3;
   logic [AW+1:0] aj, ak;
   logic [AW+1:0] jfull, kfull;
   assign jfull = (AW+2)'(cmd.j);
   assign kfull = (AW+2)'(cmd.k);
   assign aj = (AW+2)'(jfull * 3 + (AW+2)'(cmd.axis));
   assign ak = (AW+2)'(kfull * 3 + (AW+2)'(cmd.axis));

   logic [AW-1:0] ld_idx;
   logic ld_ok;
   assign ld_idx = AW'(req_data.particle_index);
   assign ld_ok = {29'd0, req_data.particle_index} < NUM_PARTICLES;
   logic [AW+1:0] ld3;
   assign ld3 = (AW+2)'((AW+2)'(ld_idx) * 3);

   always_ff @(posedge clock) begin
      if (cmd.load && ld_ok) begin
         pos_mem[ld3] <= req_data.load_pos_x;
         pos_mem[ld3 + 1] <= req_data.load_pos_y;
         pos_mem[ld3 + 2] <= req_data.load_pos_z;
         vel_mem[ld3] <= req_data.load_vel_x;
         vel_mem[ld3 + 1] <= req_data.load_vel_y;
         vel_mem[ld3 + 2] <= req_data.load_vel_z;
         mass_mem[ld_idx] <= req_data.load_mass;
      end else if (cmd.up_write) begin
         pos_mem[aj] <= np;
         vel_mem[aj] <= nbpfi_pkg::sat32(50'(vel_ff) + 50'(adt_ff));
      end
      if (cmd.pf_read) begin
         xj_ff <= pos_mem[aj];
         xk_ff <= pos_mem[ak];
         mj_ff <= mass_mem[cmd.j[AW-1:0]];
         mk_ff <= mass_mem[cmd.k[AW-1:0]];
      end
      if (cmd.up_read) begin
         xj_ff <= pos_mem[aj];
         vel_ff <= vel_mem[aj];
         f_ff <= force_ff[aj];
         mj_ff <= mass_mem[cmd.j[AW-1:0]];
      end
   end

   logic signed [48:0] fsum, fsgn;

   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         for (int i = 0; i < NI; i++) force_ff[i] <= '0;
      end else if (cmd.pf_acc) begin
         force_ff[aj] <= (fsum > nbpfi_pkg::ForceMax) ? nbpfi_pkg::ForceMax :
                         (fsum < -nbpfi_pkg::ForceMax) ? -nbpfi_pkg::ForceMax : fsum[47:0];
      end
   end

   assign fsgn = (xj_ff < xk_ff) ? $signed({1'b0, div_q[47:0]}) : -$signed({1'b0, div_q[47:0]});
   assign fsum = 49'(force_ff[aj]) + fsgn;

   assign dx = 33'(xk_ff) - 33'(xj_ff);
   assign mag = dx[32] ? 33'(-dx) : 33'(dx);
   assign dmin = (min_distance == 31'd0) ? 32'd1 : {1'b0, min_distance};
   assign mag_c = (mag < {1'b0, dmin}) ? {1'b0, dmin} : mag;
   assign fabs = f_ff[47] ? 48'(-f_ff) : 48'(f_ff);
   assign mj_eff = (mj_ff == 16'd0) ? 16'd1 : mj_ff;

   // one divider shared by pair force and force/mass
   always_comb begin
      if (cmd.pf_read || cmd.pf_acc || !cmd.up_read) begin
         div_a = {32'(mj_ff) * 32'(mk_ff), 48'd0};
         div_b = 64'(mag_c) * 64'(mag_c);
         div_n = 7'd80;
         div_max = 64'(nbpfi_pkg::ForceMax);
      end else begin
         div_a = 80'(fabs);
         div_b = 64'(mj_eff);
         div_n = 7'd48;
         div_max = '1;
      end
   end
   logic up_mode_ff;
   always_ff @(posedge clock) begin
      if (reset) up_mode_ff <= 1'b0;
      else if (cmd.up_read) up_mode_ff <= 1'b1;
      else if (cmd.pf_read) up_mode_ff <= 1'b0;
   end
   logic [79:0] div_a_m;
   logic [63:0] div_b_m, div_max_m;
   logic [6:0] div_n_m;
   always_comb begin
      if (up_mode_ff) begin
         div_a_m = 80'(fabs);
         div_b_m = 64'(mj_eff);
         div_n_m = 7'd48;
         div_max_m = '1;
      end else begin
         div_a_m = div_a;
         div_b_m = div_b;
         div_n_m = div_n;
         div_max_m = div_max;
      end
   end
   assign div_start = cmd.div_start;

   nbpfi_div u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .dividend(div_a_m), .divisor(div_b_m), .nbits(div_n_m), .qmax(div_max_m),
      .done(div_done), .quotient(div_q)
   );

   // sequenced dt multiplies, 64x16 partial products one per cycle
   logic signed [63:0] mop;
   logic [15:0] dpart;
   always_comb begin
      case (mstep_ff)
         3'd0, 3'd1: mop = 64'(acc_ff);
         3'd2, 3'd3: mop = adt_ff;
         default: mop = 64'(vel_ff);
      endcase
      dpart = mstep_ff[0] ? time_step[31:16] : time_step[15:0];
      prod_lo = 82'(mop) * $signed({1'b0, dpart});
      prod_hi = 82'(tmp_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mstep_ff <= '0;
      end else if (cmd.up_read) begin
         mstep_ff <= '0;
      end else if (cmd.up_mul && mstep_ff != 3'd6) begin
         mstep_ff <= mstep_ff + 3'd1;
      end
      if (div_done && up_mode_ff) begin
         acc_ff <= f_ff[47] ? -$signed(div_q[47:0]) : $signed(div_q[47:0]);
      end
      if (cmd.up_mul) begin
         case (mstep_ff)
            3'd0, 3'd2: tmp_ff <= fshr(prod_lo, 16);
            3'd1: adt_ff <= fshr(82'(prod_lo) + prod_hi, 16);
            3'd3: half_ff <= fshr(82'(fshr(82'(prod_lo) + prod_hi, 16)), 1);
            3'd4: tmp_ff <= prod_lo[63:0];
            3'd5: vdt_ff <= fshr((82'(prod_lo) <<< 16) + prod_hi, 32);
            default: ;
         endcase
      end
   end

   assign pos_sum = 50'(xj_ff) + 50'(vdt_ff) + 50'(half_ff);
   assign np = nbpfi_pkg::sat32(pos_sum);

   always_ff @(posedge clock) begin
      if (cmd.up_write) res_ff[cmd.axis] <= np;
   end

   always_comb begin
      rsp_data.out_index = 3'(cmd.j);
      rsp_data.out_pos_x = res_ff[0];
      rsp_data.out_pos_y = res_ff[1];
      rsp_data.out_pos_z = res_ff[2];
      rsp_data.out_last = (cmd.j == 6'(NUM_PARTICLES - 1));
   end

   assign sts.div_done = div_done;
   assign sts.mul_done = (mstep_ff == 3'd6);

endmodule

/* rtl/nbpfi_ctrl.sv */
module nbpfi_ctrl #(
   parameter int NUM_PARTICLES = nbpfi_pkg::NumParticlesDefault
) (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_ready,
   input logic req_kind,
   output logic rsp_valid,
   input logic rsp_ready,
   output nbpfi_pkg::cmd_type cmd,
   input nbpfi_pkg::sts_type sts
);

   nbpfi_pkg::state_type state_ff, state_in;
   logic [5:0] j_ff, j_in, k_ff, k_in;
   logic [1:0] a_ff, a_in;
   logic prev_rd_ff;
   localparam logic [5:0] Last = 6'(NUM_PARTICLES - 1);

   always_comb begin
      state_in = state_ff;
      j_in = j_ff;
      k_in = k_ff;
      a_in = a_ff;
      case (state_ff)
         nbpfi_pkg::ST_IDLE: begin
            if (req_valid && req_kind == nbpfi_pkg::ReqStep) begin
               state_in = nbpfi_pkg::ST_CLEAR;
               j_in = '0;
               k_in = 6'd1;
               a_in = '0;
            end
         end
         nbpfi_pkg::ST_CLEAR: state_in = nbpfi_pkg::ST_PF_RD;
         nbpfi_pkg::ST_PF_RD: state_in = nbpfi_pkg::ST_PF_DIV;
         nbpfi_pkg::ST_PF_DIV: if (sts.div_done) state_in = nbpfi_pkg::ST_PF_ACC;
         nbpfi_pkg::ST_PF_ACC: begin
            state_in = nbpfi_pkg::ST_PF_RD;
            if (a_ff != 2'd2) a_in = a_ff + 2'd1;
            else begin
               a_in = '0;
               if (k_ff == Last || (k_ff == Last - 6'd1 && j_ff == Last)) begin
                  k_in = (j_ff == 6'd0) ? 6'd0 : 6'd0;
                  if (j_ff == Last) begin
                     j_in = '0;
                     state_in = nbpfi_pkg::ST_UP_RD;
                  end else begin
                     j_in = j_ff + 6'd1;
                     k_in = 6'd0;
                  end
               end else begin
                  k_in = (k_ff + 6'd1 == j_ff) ? k_ff + 6'd2 : k_ff + 6'd1;
               end
            end
         end
         nbpfi_pkg::ST_UP_RD: state_in = nbpfi_pkg::ST_UP_DIV;
         nbpfi_pkg::ST_UP_DIV: if (sts.div_done) state_in = nbpfi_pkg::ST_UP_MUL;
         nbpfi_pkg::ST_UP_MUL: if (sts.mul_done) state_in = nbpfi_pkg::ST_UP_WR;
         nbpfi_pkg::ST_UP_WR: begin
            if (a_ff != 2'd2) begin
               a_in = a_ff + 2'd1;
               state_in = nbpfi_pkg::ST_UP_RD;
            end else state_in = nbpfi_pkg::ST_EMIT;
         end
         nbpfi_pkg::ST_EMIT: begin
            if (rsp_ready) begin
               a_in = '0;
               if (j_ff == Last) state_in = nbpfi_pkg::ST_IDLE;
               else begin
                  j_in = j_ff + 6'd1;
                  state_in = nbpfi_pkg::ST_UP_RD;
               end
            end
         end
         default: state_in = nbpfi_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      cmd.j = j_ff;
      cmd.k = (state_ff == nbpfi_pkg::ST_PF_RD && k_ff == j_ff) ? k_ff + 6'd1 : k_ff;
      cmd.axis = a_ff;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         nbpfi_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load = req_valid && req_kind == nbpfi_pkg::ReqLoad;
         end
         nbpfi_pkg::ST_CLEAR: cmd.clear = 1'b1;
         nbpfi_pkg::ST_PF_RD: cmd.pf_read = 1'b1;
         nbpfi_pkg::ST_PF_DIV: cmd.div_start = 1'b0;
         nbpfi_pkg::ST_PF_ACC: cmd.pf_acc = 1'b1;
         nbpfi_pkg::ST_UP_RD: cmd.up_read = 1'b1;
         nbpfi_pkg::ST_UP_MUL: cmd.up_mul = 1'b1;
         nbpfi_pkg::ST_UP_WR: cmd.up_write = 1'b1;
         nbpfi_pkg::ST_EMIT: rsp_valid = 1'b1;
         default: ;
      endcase
      // divider launches on the cycle after operands are registered
      if (state_ff == nbpfi_pkg::ST_PF_DIV && prev_rd_ff) cmd.div_start = 1'b1;
      if (state_ff == nbpfi_pkg::ST_UP_DIV && prev_rd_ff) cmd.div_start = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= nbpfi_pkg::ST_IDLE;
         j_ff <= '0;
         k_ff <= '0;
         a_ff <= '0;
         prev_rd_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         j_ff <= j_in;
         k_ff <= (state_in == nbpfi_pkg::ST_PF_RD && k_in == j_in) ? k_in + 6'd1 : k_in;
         a_ff <= a_in;
         prev_rd_ff <= (state_ff == nbpfi_pkg::ST_PF_RD) || (state_ff == nbpfi_pkg::ST_UP_RD);
      end
   end

endmodule

/* rtl/nbody_pairwise_force_integrator.sv */
// A step request's run time depends on the data, and the receiver can hold off a result:
// every pair force and every force/mass goes through one shared bit-per-cycle divider,
// and a pair force that saturates finishes early. A load request is taken while the
// block is idle. Results stream one per particle in index order; out_last marks the
// final one.
module nbody_pairwise_force_integrator #(
   parameter int NUM_PARTICLES = nbpfi_pkg::NumParticlesDefault
) (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_ready,
   input nbpfi_pkg::req_type_type req_data,
   output logic rsp_valid,
   input logic rsp_ready,
   output nbpfi_pkg::rsp_type_type rsp_data,
   input logic csr_we,
   input logic csr_index,
   input logic [31:0] csr_wdata
);

   logic [31:0] time_step_ff;
   logic [30:0] min_dist_ff;
   nbpfi_pkg::cmd_type cmd;
   nbpfi_pkg::sts_type sts;

   always_ff @(posedge clock) begin
      if (reset) begin
         time_step_ff <= nbpfi_pkg::TimeStepReset;
         min_dist_ff <= nbpfi_pkg::MinDistReset;
      end else if (csr_we) begin
         case (csr_index)
            nbpfi_pkg::CsrTimeStep: time_step_ff <= csr_wdata;
            nbpfi_pkg::CsrMinDist: min_dist_ff <= csr_wdata[30:0];
            default: ;
         endcase
      end
   end

   nbpfi_ctrl #(.NUM_PARTICLES(NUM_PARTICLES)) u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
      .req_kind(req_data.req_type), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .cmd(cmd), .sts(sts)
   );

   nbpfi_datapath #(.NUM_PARTICLES(NUM_PARTICLES)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .sts(sts), .req_data(req_data),
      .time_step(time_step_ff), .min_distance(min_dist_ff), .rsp_data(rsp_data)
   );

endmodule
